/* sv/lbc_pkg.sv */
// shared types and codes for the block cache slot manager
package lbc_pkg;

  localparam int NUM_SLOTS_DEF  = 1024;
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int CAP_W          = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [1:0] OP_ACQUIRE  = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_PREFETCH = 2'd2;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_NOSLOT    = 3'd3;
  localparam logic [2:0] ST_NOTPINNED = 3'd4;
  localparam logic [2:0] ST_BUSY      = 3'd5;

  typedef enum logic [2:0] {
    K_ACQUIRE,
    K_PREFETCH,
    K_RELEASE,
    K_NOSLOT,
    K_NOTPINNED
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] bid;
    logic [9:0]  sidx;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic        evicted;
    logic [11:0] evicted_block;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_PIN,
    S_HUNL,
    S_EVU,
    S_EVM,
    S_REL,
    S_REL2,
    S_DONE
  } state_t;

endpackage

/* sv/lbc_if.sv */
// request and result channel interfaces
interface lbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] blk_num;
  logic [9:0]  slot_index;
  modport source (output valid, operation, blk_num, slot_index, input ready);
  modport sink (input valid, operation, blk_num, slot_index, output ready);
endinterface

interface lbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot;
  logic        evicted;
  logic [11:0] evicted_block;
  modport source (output valid, status, slot, evicted, evicted_block, input ready);
  modport sink (input valid, status, slot, evicted, evicted_block, output ready);
endinterface

/* sv/lbc_ram.sv */
// generic single write port ram with registered read
module lbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/lbc_front.sv */
// request intake, classification and two entry queue
module lbc_front #(
  parameter int NUM_SLOTS  = lbc_pkg::NUM_SLOTS_DEF,
  parameter int MAX_BLOCKS = lbc_pkg::MAX_BLOCKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lbc_in_if.sink        in_itm,
  input  logic          clearing,
  input  logic          pop,
  output logic          q_valid,
  output lbc_pkg::req_t q_head
);
  import lbc_pkg::*;

  req_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       cls;
  logic       push;

  always_comb begin
    cls.bid  = in_itm.blk_num;
    cls.sidx = in_itm.slot_index;
    case (in_itm.operation)
      OP_RELEASE: begin
        cls.kind = (32'(in_itm.slot_index) >= NUM_SLOTS) ? K_NOTPINNED : K_RELEASE;
      end
      OP_ACQUIRE: begin
        cls.kind = (32'(in_itm.blk_num) >= MAX_BLOCKS) ? K_NOSLOT : K_ACQUIRE;
      end
      OP_PREFETCH: begin
        cls.kind = (32'(in_itm.blk_num) >= MAX_BLOCKS) ? K_NOSLOT : K_PREFETCH;
      end
      default: begin
        cls.kind = K_NOSLOT;
      end
    endcase
  end

  assign in_itm.ready = !clearing && (cnt_r != 2'd2);
  assign push    = in_itm.valid && in_itm.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end
endmodule

/* sv/lbc_back.sv */
// slot map and lru list sequencer with result register
module lbc_back #(
  parameter int NUM_SLOTS  = lbc_pkg::NUM_SLOTS_DEF,
  parameter int MAX_BLOCKS = lbc_pkg::MAX_BLOCKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lbc_pkg::CAP_W-1:0] cap,
  input  logic                     q_valid,
  input  lbc_pkg::req_t            q_head,
  output logic                     pop,
  output logic                     clearing,
  lbc_out_if.source                out_res
);
  import lbc_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int D  = (NUM_SLOTS > MAX_BLOCKS) ? NUM_SLOTS : MAX_BLOCKS;
  localparam int CW = $clog2(D);

  state_t        state_r, state_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt, s_r, s_nxt;
  logic [SW:0]   cnt_r, cnt_nxt, used_r, used_nxt;
  req_t          cur_r, cur_nxt;
  res_t          res_r, res_nxt, out_r;
  logic          out_valid_r;
  logic          out_free;

  logic          map_we;
  logic [BW-1:0] map_waddr, map_raddr;
  logic [SW:0]   map_wdata, map_rd;
  logic          pin_we, pin_wdata, pin_rd;
  logic [SW-1:0] pin_waddr, pin_raddr;
  logic          own_we;
  logic [SW-1:0] own_waddr, lst_raddr;
  logic [BW-1:0] own_wdata, own_rd;
  logic          prv_we, nxt_we;
  logic [SW-1:0] prv_waddr, prv_wdata, prv_rd, nxt_waddr, nxt_wdata, nxt_rd;

  logic          map_vld, fresh;
  logic [SW-1:0] map_slot;
  logic [BW-1:0] cur_bid;

  lbc_ram #(.WIDTH(SW + 1), .DEPTH(MAX_BLOCKS)) u_map (
    .clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata), .raddr(map_raddr), .rdata(map_rd)
  );
  lbc_ram #(.WIDTH(1), .DEPTH(NUM_SLOTS)) u_pin (
    .clk, .we(pin_we), .waddr(pin_waddr), .wdata(pin_wdata), .raddr(pin_raddr), .rdata(pin_rd)
  );
  lbc_ram #(.WIDTH(BW), .DEPTH(NUM_SLOTS)) u_own (
    .clk, .we(own_we), .waddr(own_waddr), .wdata(own_wdata), .raddr(lst_raddr), .rdata(own_rd)
  );
  lbc_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_prv (
    .clk, .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata), .raddr(lst_raddr), .rdata(prv_rd)
  );
  lbc_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata), .raddr(lst_raddr), .rdata(nxt_rd)
  );

  assign map_vld  = map_rd[SW];
  assign map_slot = map_rd[SW-1:0];
  assign cur_bid  = BW'(cur_r.bid);
  assign fresh    = (32'(used_r) < 32'(cap)) && (32'(used_r) < NUM_SLOTS);
  assign out_free = !out_valid_r || out_res.ready;
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (32'(clr_r) == D - 1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            K_ACQUIRE, K_PREFETCH: state_nxt = S_MAP;
            K_RELEASE:             state_nxt = S_REL;
            default:               state_nxt = S_DONE;
          endcase
        end
      end
      S_MAP: begin
        if (map_vld) begin
          state_nxt = (cur_r.kind == K_PREFETCH) ? S_DONE : S_PIN;
        end else if (fresh || cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_EVU;
        end
      end
      S_PIN:  state_nxt = pin_rd ? S_DONE : S_HUNL;
      S_HUNL: state_nxt = S_DONE;
      S_EVU:  state_nxt = S_EVM;
      S_EVM:  state_nxt = S_DONE;
      S_REL:  state_nxt = (!pin_rd || cnt_r == '0) ? S_DONE : S_REL2;
      S_REL2: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    clr_nxt   = clr_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    s_nxt     = s_r;
    cur_nxt   = cur_r;
    res_nxt   = res_r;
    map_raddr = BW'(q_head.bid);
    pin_raddr = (state_r == S_IDLE) ? SW'(q_head.sidx) : map_slot;
    lst_raddr = (state_r == S_MAP) ? tail_r : s_r;
    map_we    = 1'b0;
    map_waddr = cur_bid;
    map_wdata = {1'b1, s_r};
    pin_we    = 1'b0;
    pin_waddr = s_r;
    pin_wdata = 1'b1;
    own_we    = 1'b0;
    own_waddr = s_r;
    own_wdata = cur_bid;
    prv_we    = 1'b0;
    prv_waddr = nxt_rd;
    prv_wdata = prv_rd;
    nxt_we    = 1'b0;
    nxt_waddr = prv_rd;
    nxt_wdata = nxt_rd;
    case (state_r)
      S_CLEAR: begin
        clr_nxt   = clr_r + 1'b1;
        map_we    = (32'(clr_r) < MAX_BLOCKS);
        map_waddr = BW'(clr_r);
        map_wdata = '0;
        pin_we    = (32'(clr_r) < NUM_SLOTS);
        pin_waddr = SW'(clr_r);
        pin_wdata = 1'b0;
      end
      S_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          cur_nxt = q_head;
          s_nxt   = SW'(q_head.sidx);
          res_nxt = '{status: (q_head.kind inside {K_NOTPINNED, K_RELEASE}) ?
                              ST_NOTPINNED : ST_NOSLOT,
                      slot: '0, evicted: 1'b0, evicted_block: '0};
        end
      end
      S_MAP: begin
        if (map_vld) begin
          s_nxt   = map_slot;
          res_nxt = '{status: ST_PRESENT, slot: 10'(map_slot), evicted: 1'b0,
                      evicted_block: '0};
        end else if (fresh) begin
          used_nxt  = used_r + 1'b1;
          own_we    = 1'b1;
          own_waddr = used_r[SW-1:0];
          pin_we    = 1'b1;
          pin_waddr = used_r[SW-1:0];
          map_we    = 1'b1;
          map_wdata = {1'b1, used_r[SW-1:0]};
          res_nxt   = '{status: ST_MISS, slot: 10'(used_r[SW-1:0]), evicted: 1'b0,
                        evicted_block: '0};
        end else begin
          s_nxt = tail_r;
        end
      end
      S_PIN: begin
        res_nxt = '{status: ST_BUSY, slot: 10'(s_r), evicted: 1'b0, evicted_block: '0};
      end
      S_HUNL, S_EVU: begin
        if (s_r == head_r) head_nxt = nxt_rd;
        else nxt_we = 1'b1;
        if (s_r == tail_r) tail_nxt = prv_rd;
        else prv_we = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        pin_we  = 1'b1;
        if (state_r == S_HUNL) begin
          res_nxt = '{status: ST_HIT, slot: 10'(s_r), evicted: 1'b0, evicted_block: '0};
        end else begin
          map_we    = 1'b1;
          map_waddr = own_rd;
          map_wdata = '0;
          own_we    = 1'b1;
          res_nxt   = '{status: ST_MISS, slot: 10'(s_r), evicted: 1'b1,
                        evicted_block: 12'(own_rd)};
        end
      end
      S_EVM: begin
        map_we = 1'b1;
      end
      S_REL: begin
        if (pin_rd) begin
          pin_we    = 1'b1;
          pin_wdata = 1'b0;
          nxt_we    = 1'b1;
          nxt_waddr = s_r;
          nxt_wdata = head_r;
          prv_we    = 1'b1;
          prv_waddr = s_r;
          prv_wdata = s_r;
          res_nxt   = '{status: ST_HIT, slot: 10'(s_r), evicted: 1'b0, evicted_block: '0};
          if (cnt_r == '0) begin
            tail_nxt = s_r;
            head_nxt = s_r;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
      end
      S_REL2: begin
        prv_we    = 1'b1;
        prv_waddr = head_r;
        prv_wdata = s_r;
        head_nxt  = s_r;
        cnt_nxt   = cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    s_r   <= s_nxt;
    cur_r <= cur_nxt;
    res_r <= res_nxt;
    if (state_r == S_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = out_r.status;
  assign out_res.slot          = out_r.slot;
  assign out_res.evicted       = out_r.evicted;
  assign out_res.evicted_block = out_r.evicted_block;

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !pop) else $error("item taken outside idle");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= NUM_SLOTS) else $error("slots used above slot count");
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= used_r) else $error("lru list longer than slots used");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r) else $error("result dropped");
endmodule

/* sv/lru_block_cache_slot_manager.sv */
// top level of the block cache slot manager with config registers
// states per item: errors go from idle to done, a fresh miss through map, a release through
// one or two release states, a hit through map, pin and unlink, an eviction through map,
// unlink and evict; the single sequencer over the rams works on one item at a time
// reset: synchronous active low; a clearing pass over all addresses
// wipes the block map and pin bits, no item is accepted during it
// capacity register resets to 1024
module lru_block_cache_slot_manager #(
  parameter int NUM_SLOTS  = lbc_pkg::NUM_SLOTS_DEF,
  parameter int MAX_BLOCKS = lbc_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lbc_in_if.sink      in_itm,
  lbc_out_if.source   out_res,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbc_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             clearing, pop, q_valid;
  req_t             q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  lbc_front #(.NUM_SLOTS(NUM_SLOTS), .MAX_BLOCKS(MAX_BLOCKS)) u_front (
    .clk, .rst_n, .in_itm, .clearing, .pop, .q_valid, .q_head
  );

  lbc_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk, .rst_n, .cap(cap_r), .q_valid, .q_head, .pop, .clearing, .out_res
  );
endmodule
